// ===== rtl/ymodem_packet_receiver_core_macros.svh =====
// Assertion macros shared by the packet receiver RTL.
// Each macro takes a label, the clock, the reset, a condition, a consequence
// and the message text that is reported on a failure.
`ifndef YMODEM_PACKET_RECEIVER_CORE_MACROS_SVH
`define YMODEM_PACKET_RECEIVER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// The consequence must hold in the same cycle as the condition.
`define YMR_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// The consequence must hold in the cycle after the condition.
`define YMR_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`else

`define YMR_ASSERT_SAME(label, clk, rst, cond, cons, msg)
`define YMR_ASSERT_NEXT(label, clk, rst, cond, cons, msg)

`endif

`endif

// ===== rtl/ymr_pkg.sv =====
package ymr_pkg;

   // Fixed field widths.
   localparam int TIMEOUT_W = 24;
   localparam int BYTE_W    = 8;
   localparam int KIND_W    = 4;
   localparam int COUNT_W   = 10;
   localparam int LEN_W     = 11;
   localparam int CRC_W     = 16;

   // Block sizes and the default timer width.
   localparam int SHORT_BLOCK    = 128;
   localparam int LONG_BLOCK     = 1024;
   localparam int TIMER_BITS_DEF = 24;

   // Configuration port geometry.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // Register indexes.
   localparam logic [1:0] REG_TIMEOUT = 2'd0;
   localparam logic [1:0] REG_ABORT_A = 2'd1;
   localparam logic [1:0] REG_ABORT_B = 2'd2;

   // Register reset values.
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd1000;
   localparam logic [BYTE_W-1:0]    ABORT_A_RESET = 8'h41;
   localparam logic [BYTE_W-1:0]    ABORT_B_RESET = 8'h61;

   // Lead bytes.
   localparam logic [BYTE_W-1:0] LEAD_SOH = 8'h01;
   localparam logic [BYTE_W-1:0] LEAD_STX = 8'h02;
   localparam logic [BYTE_W-1:0] LEAD_EOT = 8'h04;
   localparam logic [BYTE_W-1:0] LEAD_CA  = 8'h18;

   // Result kinds.
   localparam logic [KIND_W-1:0] K_PAYLOAD = 4'd0;
   localparam logic [KIND_W-1:0] K_GOOD    = 4'd1;
   localparam logic [KIND_W-1:0] K_EOT     = 4'd2;
   localparam logic [KIND_W-1:0] K_SCANCEL = 4'd3;
   localparam logic [KIND_W-1:0] K_UABORT  = 4'd4;
   localparam logic [KIND_W-1:0] K_BADLEAD = 4'd5;
   localparam logic [KIND_W-1:0] K_NUMBAD  = 4'd6;
   localparam logic [KIND_W-1:0] K_CRCBAD  = 4'd7;
   localparam logic [KIND_W-1:0] K_TIMEOUT = 4'd8;
   localparam logic [KIND_W-1:0] K_CANUNC  = 4'd9;

   // CRC-16/XMODEM generator polynomial.
   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

   // Configuration values handed from the register block to the datapath.
   typedef struct packed {
      logic [TIMEOUT_W-1:0] timeout_ticks;
      logic [BYTE_W-1:0]    abort_char_a;
      logic [BYTE_W-1:0]    abort_char_b;
   } cfg_type;

   // One byte of CRC-16/XMODEM, most significant bit first.
   function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/ymr_csr.sv =====
module ymr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ymr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ymr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ymr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output ymr_pkg::cfg_type                 cfg_out
);
   import ymr_pkg::*;

   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [BYTE_W-1:0]    abort_a_ff;
   logic [BYTE_W-1:0]    abort_b_ff;
   logic [1:0]           reg_index;
   logic                 write_strobe;

   // The register index is the word address.
   assign reg_index    = csr_paddr[3:2];
   assign csr_pready   = 1'b1;
   assign write_strobe = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Register writes in the access phase; unused addresses are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         abort_a_ff <= ABORT_A_RESET;
         abort_b_ff <= ABORT_B_RESET;
      end else if (write_strobe) begin
         case (reg_index)
            REG_TIMEOUT: timeout_ff <= csr_pwdata[TIMEOUT_W-1:0];
            REG_ABORT_A: abort_a_ff <= csr_pwdata[BYTE_W-1:0];
            REG_ABORT_B: abort_b_ff <= csr_pwdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back of the register selected by the address.
   always_comb begin
      case (reg_index)
         REG_TIMEOUT: csr_prdata = {{(CSR_DATA_W-TIMEOUT_W){1'b0}}, timeout_ff};
         REG_ABORT_A: csr_prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, abort_a_ff};
         REG_ABORT_B: csr_prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, abort_b_ff};
         default:     csr_prdata = '0;
      endcase
   end

   assign cfg_out.timeout_ticks = timeout_ff;
   assign cfg_out.abort_char_a  = abort_a_ff;
   assign cfg_out.abort_char_b  = abort_b_ff;

endmodule

// ===== rtl/ymodem_packet_receiver_core.sv =====
// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    req_mode, req_rx_byte
// rsp       out        rsp_valid/stall    rsp_kind .. rsp_verdict_last
// csr       in/out     APB psel/penable   paddr, pwdata, prdata
//
// One request is taken every cycle unless req_stall holds it off; its result, if
// any, is registered into the output register, or the skid entry while it stalls.
// The limit is the combinational CRC byte update and phase decode before them.
// Reset is synchronous and returns the receiver to waiting for a lead byte.
// A two-entry output buffer absorbs a stalled result; req_stall rises only
// while its second entry is occupied.
`include "ymodem_packet_receiver_core_macros.svh"

module ymodem_packet_receiver_core #(
   parameter int TIMER_BITS = ymr_pkg::TIMER_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_mode,
   input  logic [ymr_pkg::BYTE_W-1:0]       req_rx_byte,
   // Result channel.
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ymr_pkg::KIND_W-1:0]       rsp_kind,
   output logic [ymr_pkg::BYTE_W-1:0]       rsp_payload_byte,
   output logic [ymr_pkg::COUNT_W-1:0]      rsp_byte_index,
   output logic [ymr_pkg::BYTE_W-1:0]       rsp_block_number,
   output logic [ymr_pkg::LEN_W-1:0]        rsp_payload_length,
   output logic                             rsp_verdict_last,
   // Configuration port.
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ymr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ymr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ymr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import ymr_pkg::*;

   // Receiver phases.
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_CANCEL = 3'd1;
   localparam logic [2:0] PH_NUM    = 3'd2;
   localparam logic [2:0] PH_CNUM   = 3'd3;
   localparam logic [2:0] PH_DATA   = 3'd4;
   localparam logic [2:0] PH_CRCH   = 3'd5;
   localparam logic [2:0] PH_CRCL   = 3'd6;

   // Width that holds both the tick counter and the timeout register.
   localparam int CMP_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [BYTE_W-1:0]  payload_byte;
      logic [COUNT_W-1:0] byte_index;
      logic [BYTE_W-1:0]  block_number;
      logic [LEN_W-1:0]   payload_length;
      logic               verdict_last;
   } rsp_type;

   cfg_type cfg;

   logic [2:0]            phase_ff, phase_in;
   logic                  long_ff, long_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [BYTE_W-1:0]     number_ff, number_in;
   logic                  number_bad_ff, number_bad_in;
   logic [CRC_W-1:0]      crc_ff, crc_in;
   logic [BYTE_W-1:0]     trailer_ff, trailer_in;
   logic [TIMER_BITS-1:0] tick_ff, tick_in;

   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;
   logic                  skid_valid_ff, skid_valid_in;
   rsp_type               skid_ff, skid_in;

   logic                  accept;
   logic                  res_valid;
   rsp_type               res;
   logic [TIMER_BITS-1:0] tick_next;
   logic                  timed_out;
   logic [COUNT_W-1:0]    last_index;
   logic [LEN_W-1:0]      block_len;

   ymr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg_out     (cfg)
   );

   // Requests are held off only while both output entries are full.
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~req_stall;

   // Saturating tick count and timeout compare.
   assign tick_next = (&tick_ff) ? tick_ff : tick_ff + 1'b1;
   assign timed_out = CMP_W'(tick_next) >= CMP_W'(cfg.timeout_ticks);

   // Block geometry.
   assign last_index = long_ff ? COUNT_W'(LONG_BLOCK - 1) : COUNT_W'(SHORT_BLOCK - 1);
   assign block_len  = long_ff ? LEN_W'(LONG_BLOCK) : LEN_W'(SHORT_BLOCK);

   // Per-request phase logic and result formation.
   always_comb begin
      phase_in      = phase_ff;
      long_in       = long_ff;
      count_in      = count_ff;
      number_in     = number_ff;
      number_bad_in = number_bad_ff;
      crc_in        = crc_ff;
      trailer_in    = trailer_ff;
      tick_in       = tick_ff;
      res_valid     = 1'b0;
      res           = '0;

      if (accept) begin
         if (req_mode) begin
            // A timer tick either advances the wait or ends it.
            if (timed_out) begin
               res_valid        = 1'b1;
               res.verdict_last = 1'b1;
               phase_in         = PH_IDLE;
               tick_in          = '0;
               if (phase_ff == PH_CANCEL) begin
                  res.kind = K_CANUNC;
               end else if (phase_ff >= PH_NUM && phase_ff <= PH_CRCL) begin
                  res.kind         = K_TIMEOUT;
                  res.block_number = number_ff;
               end else begin
                  res.kind = K_TIMEOUT;
               end
            end else begin
               tick_in = tick_next;
            end
         end else begin
            case (phase_ff)
               PH_CANCEL: begin
                  res_valid        = 1'b1;
                  res.verdict_last = 1'b1;
                  res.kind         = (req_rx_byte == LEAD_CA) ? K_SCANCEL : K_CANUNC;
                  phase_in         = PH_IDLE;
                  tick_in          = '0;
               end
               PH_NUM: begin
                  number_in = req_rx_byte;
                  phase_in  = PH_CNUM;
               end
               PH_CNUM: begin
                  number_bad_in = (number_ff != ~req_rx_byte);
                  phase_in      = PH_DATA;
               end
               PH_DATA: begin
                  // Payload bytes go out as they arrive.
                  crc_in           = crc16_byte(crc_ff, req_rx_byte);
                  res_valid        = 1'b1;
                  res.kind         = K_PAYLOAD;
                  res.payload_byte = req_rx_byte;
                  res.byte_index   = count_ff;
                  res.block_number = number_ff;
                  if (count_ff == last_index) begin
                     count_in = '0;
                     phase_in = PH_CRCH;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end
               PH_CRCH: begin
                  trailer_in = req_rx_byte;
                  phase_in   = PH_CRCL;
               end
               PH_CRCL: begin
                  // A number mismatch outranks a CRC failure.
                  res_valid        = 1'b1;
                  res.verdict_last = 1'b1;
                  res.block_number = number_ff;
                  phase_in         = PH_IDLE;
                  tick_in          = '0;
                  if (number_bad_ff) begin
                     res.kind = K_NUMBAD;
                  end else if ({trailer_ff, req_rx_byte} != crc_ff) begin
                     res.kind = K_CRCBAD;
                  end else begin
                     res.kind           = K_GOOD;
                     res.payload_length = block_len;
                  end
               end
               default: begin
                  // Lead byte classification; protocol bytes win over abort chars.
                  tick_in = '0;
                  if (req_rx_byte == LEAD_SOH || req_rx_byte == LEAD_STX) begin
                     long_in       = (req_rx_byte == LEAD_STX);
                     count_in      = '0;
                     number_in     = '0;
                     number_bad_in = 1'b0;
                     crc_in        = '0;
                     trailer_in    = '0;
                     phase_in      = PH_NUM;
                  end else if (req_rx_byte == LEAD_CA) begin
                     phase_in = PH_CANCEL;
                  end else begin
                     res_valid        = 1'b1;
                     res.verdict_last = 1'b1;
                     phase_in         = PH_IDLE;
                     if (req_rx_byte == LEAD_EOT) begin
                        res.kind = K_EOT;
                     end else if (req_rx_byte == cfg.abort_char_a ||
                                  req_rx_byte == cfg.abort_char_b) begin
                        res.kind = K_UABORT;
                     end else begin
                        res.kind = K_BADLEAD;
                     end
                  end
               end
            endcase
         end
      end
   end

   // Two-entry output buffer: the output register and a skid entry.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (!rsp_stall) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || !rsp_stall) begin
         out_valid_in = res_valid;
         if (res_valid) begin
            out_in = res;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   // Receiver state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         long_ff       <= 1'b0;
         count_ff      <= '0;
         number_ff     <= '0;
         number_bad_ff <= 1'b0;
         crc_ff        <= '0;
         trailer_ff    <= '0;
         tick_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         long_ff       <= long_in;
         count_ff      <= count_in;
         number_ff     <= number_in;
         number_bad_ff <= number_bad_in;
         crc_ff        <= crc_in;
         trailer_ff    <= trailer_in;
         tick_ff       <= tick_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_ff.kind;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_byte_index     = out_ff.byte_index;
   assign rsp_block_number   = out_ff.block_number;
   assign rsp_payload_length = out_ff.payload_length;
   assign rsp_verdict_last   = out_ff.verdict_last;

   // The skid entry only fills behind an occupied output register.
   `YMR_ASSERT_SAME(a_skid_behind_out, clock, reset,
                    skid_valid_ff, out_valid_ff,
                    "skid entry valid while output register is empty")

   // Payload bytes never carry the end-of-packet mark.
   `YMR_ASSERT_SAME(a_payload_not_last, clock, reset,
                    out_valid_ff && out_ff.kind == K_PAYLOAD, !out_ff.verdict_last,
                    "payload result marked as last")

   // A short block never counts past its length.
   `YMR_ASSERT_SAME(a_short_count, clock, reset,
                    phase_ff == PH_DATA && !long_ff, count_ff < COUNT_W'(SHORT_BLOCK),
                    "short block data count out of range")

   // Every verdict returns to the lead byte wait with a fresh timer.
   `YMR_ASSERT_NEXT(a_verdict_idle, clock, reset,
                    res_valid && res.verdict_last, phase_ff == PH_IDLE && tick_ff == '0,
                    "receiver not idle after a verdict")

endmodule
